### rtl/ssrs_pkg.sv
// ============================================================================
// Safe-stop release supervisor package
// Shared types, field layouts and codes for the supervisor modules.
// ============================================================================
package ssrs_pkg;

    // Fixed field widths of the streaming payloads
    localparam int POS_W      = 20;
    localparam int SPEED_W    = 17;
    localparam int STOP_W     = 16;
    localparam int CONFIRM_W  = 8;
    localparam int SEQ_W      = 32;
    localparam int STREAK_O_W = 16;
    localparam int REM_W      = POS_W + 1;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 8;

    // Item kinds carried on s_tuser
    localparam logic [1:0] KIND_EVAL     = 2'd0;
    localparam logic [1:0] KIND_ACTIVATE = 2'd1;
    localparam logic [1:0] KIND_RESET    = 2'd2;

    // Release causes
    localparam logic [1:0] CAUSE_NONE          = 2'd0;
    localparam logic [1:0] CAUSE_PASSED        = 2'd1;
    localparam logic [1:0] CAUSE_AVOIDANCE     = 2'd2;
    localparam logic [1:0] CAUSE_STOPPED_CLEAR = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_LEN    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_MARGIN  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOPPED_SPD  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM      = 8'd3;

    // Input payload, last field in the lowest bits
    typedef struct packed {
        logic [6:0]              pad;
        logic [POS_W-1:0]        danger_end_mm;
        logic [POS_W-1:0]        activation_position_mm;
        logic [SEQ_W-1:0]        frame_sequence;
        logic                    corridor_clear;
        logic                    obstacles_empty;
        logic                    can_select_avoidance;
        logic                    avoidance_valid;
        logic signed [SPEED_W-1:0] ego_speed_mm_s;
        logic [POS_W-1:0]        ego_position_mm;
    } in_data_t;

    // Result payload, last field in the lowest bits
    typedef struct packed {
        logic [5:0]              pad;
        logic [STREAK_O_W-1:0]   clear_streak_out;
        logic [STREAK_O_W-1:0]   avoid_streak_out;
        logic                    handoff_allowed;
        logic [1:0]              release_cause;
        logic                    release_ok;
        logic                    cond_c;
        logic                    cond_b;
        logic                    cond_a;
        logic                    vehicle_stopped;
        logic                    obstacle_passed;
        logic                    is_active;
    } out_data_t;

    // Configuration register set
    typedef struct packed {
        logic [POS_W-1:0]     track_len;
        logic [POS_W-1:0]     pass_margin;
        logic [STOP_W-1:0]    stop_speed;
        logic [CONFIRM_W-1:0] confirm;
    } cfg_t;

    // Per-item context travelling down the remainder pipeline
    typedef struct packed {
        logic                  active;
        logic                  stopped;
        logic                  cond_b;
        logic                  cond_c;
        logic                  neg;
        logic [REM_W-1:0]      rem;
        logic [POS_W-1:0]      dividend;
        logic [REM_W-1:0]      pass_need;
        logic [STREAK_O_W-1:0] avoid_out;
        logic [STREAK_O_W-1:0] clear_out;
    } pipe_t;

endpackage

### rtl/safe_stop_release_supervisor_top.sv
// ============================================================================
// Safe-stop release supervisor
// Latched safe stop with release by obstacle passed, avoidance or stopped clear.
// ============================================================================
// Items arrive on the s_ stream: s_tuser carries the kind (evaluate, activate,
// reset), s_tdata the position, speed, planner flags and frame number. Each
// evaluate transfer yields exactly one result transfer on the m_ stream;
// activate and reset transfers only change the latched state and yield none.
// Registers are written over the cfg_ channel, which is always ready; write
// them only while no item is in flight.
// Throughput is one item per clock while results are taken. A result passes the
// input register, the state stage, one restoring step per position bit for the
// modulo-lap reduction, the wrap fix-up and the result register.
// The whole pipeline advances together; when m_tready is low with a result
// waiting, every stage holds and s_tready drops until the result is taken.
// Reset clears the latch, both streaks, the pipeline valids and the registers
// (confirm count resets to one).
// ============================================================================
module safe_stop_release_supervisor_top #(
    parameter int POS_BITS    = 20,
    parameter int STREAK_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // kind [1:0]
    input  logic [1:0]                          s_tuser,
    // ego_position_mm [19:0], ego_speed_mm_s [36:20], avoidance_valid [37],
    // can_select_avoidance [38], obstacles_empty [39], corridor_clear [40],
    // frame_sequence [72:41], activation_position_mm [92:73],
    // danger_end_mm [112:93], zero fill [119:113]
    input  logic [ssrs_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // is_active [0], obstacle_passed [1], vehicle_stopped [2], cond_a [3],
    // cond_b [4], cond_c [5], release_ok [6], release_cause [8:7],
    // handoff_allowed [9], avoid_streak_out [25:10], clear_streak_out [41:26],
    // zero fill [47:42]
    output logic [ssrs_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ssrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssrs_pkg::POS_W-1:0]          cfg_data
);
    import ssrs_pkg::*;

    localparam int PW = (POS_BITS < POS_W) ? POS_BITS : POS_W;

    logic       advance;
    logic       in_valid_reg;
    logic [1:0] in_kind_reg;
    in_data_t   in_data_reg;
    cfg_t       cfg_reg;
    logic       res_valid;
    out_data_t  res_data;

    logic [PW:0] stg_valid;
    pipe_t       stg_pipe [PW+1];

    // Pipeline moves whenever the result register is free or being drained
    assign advance   = !res_valid || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.track_len   <= '0;
            cfg_reg.pass_margin <= '0;
            cfg_reg.stop_speed  <= '0;
            cfg_reg.confirm     <= CONFIRM_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TRACK_LEN:   cfg_reg.track_len   <= cfg_data;
                REG_PASS_MARGIN: cfg_reg.pass_margin <= cfg_data;
                REG_STOPPED_SPD: cfg_reg.stop_speed  <= cfg_data[STOP_W-1:0];
                REG_CONFIRM:     cfg_reg.confirm     <= cfg_data[CONFIRM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (advance)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_kind_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    // Latch and streak state
    ssrs_state #(
        .PW          (PW),
        .STREAK_BITS (STREAK_BITS)
    ) u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid_reg),
        .in_kind   (in_kind_reg),
        .in_data   (in_data_reg),
        .cfg       (cfg_reg),
        .out_valid (stg_valid[0]),
        .out_pipe  (stg_pipe[0])
    );

    // Modulo-lap reduction, one dividend bit per stage
    for (genvar i = 0; i < PW; i++)
    begin : g_mod
        ssrs_mod_step #(
            .PW   (PW),
            .STEP (i)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .track_len (cfg_reg.track_len),
            .in_valid  (stg_valid[i]),
            .in_pipe   (stg_pipe[i]),
            .out_valid (stg_valid[i+1]),
            .out_pipe  (stg_pipe[i+1])
        );
    end

    // Wrap fix-up, release decision and result register
    ssrs_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .track_len (cfg_reg.track_len),
        .in_valid  (stg_valid[PW]),
        .in_pipe   (stg_pipe[PW]),
        .out_valid (res_valid),
        .out_data  (res_data)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = res_data;

endmodule

### rtl/ssrs_state.sv
// ============================================================================
// Supervisor state stage
// Applies one item to the latch and streak state and starts the distance work.
// ============================================================================
module ssrs_state #(
    parameter int PW          = 20,
    parameter int STREAK_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  logic [1:0]       in_kind,
    input  ssrs_pkg::in_data_t in_data,
    input  ssrs_pkg::cfg_t   cfg,
    output logic             out_valid,
    output ssrs_pkg::pipe_t  out_pipe
);
    import ssrs_pkg::*;

    localparam int SW = STREAK_BITS;
    localparam int CW = (SW > CONFIRM_W) ? SW : CONFIRM_W;
    localparam logic [SW-1:0] STREAK_MAX = {SW{1'b1}};

    logic              latched_reg, latched_next;
    logic [PW-1:0]     start_reg, start_next;
    logic [PW-1:0]     danger_reg, danger_next;
    logic [SW-1:0]     avoid_reg, avoid_next;
    logic [SW-1:0]     clear_reg, clear_next;
    logic [SEQ_W-1:0]  last_frame_reg, last_frame_next;
    logic              valid_reg;
    pipe_t             pipe_reg, pipe_next;

    logic [PW-1:0]        pos;
    logic signed [PW:0]   diff;
    logic [PW-1:0]        dist_mag;
    logic [SPEED_W-1:0]   speed_mag;
    logic                 stopped;
    logic [CONFIRM_W-1:0] need;

    // Speed magnitude, driven distance sign and magnitude
    always_comb
    begin
        pos       = in_data.ego_position_mm[PW-1:0];
        diff      = $signed({1'b0, pos}) - $signed({1'b0, start_reg});
        dist_mag  = diff[PW] ? PW'(-diff) : diff[PW-1:0];
        speed_mag = in_data.ego_speed_mm_s[SPEED_W-1] ?
                    SPEED_W'(-in_data.ego_speed_mm_s) : SPEED_W'(in_data.ego_speed_mm_s);
        stopped   = speed_mag <= {1'b0, cfg.stop_speed};
        need      = (cfg.confirm == '0) ? CONFIRM_W'(1) : cfg.confirm;
    end

    // Next state for the item in the input register
    always_comb
    begin
        latched_next    = latched_reg;
        start_next      = start_reg;
        danger_next     = danger_reg;
        avoid_next      = avoid_reg;
        clear_next      = clear_reg;
        last_frame_next = last_frame_reg;
        case (in_kind)
            KIND_ACTIVATE:
            begin
                latched_next    = 1'b1;
                start_next      = in_data.activation_position_mm[PW-1:0];
                danger_next     = in_data.danger_end_mm[PW-1:0];
                avoid_next      = '0;
                clear_next      = '0;
                last_frame_next = '0;
            end
            KIND_RESET:
            begin
                latched_next    = 1'b0;
                start_next      = '0;
                danger_next     = '0;
                avoid_next      = '0;
                clear_next      = '0;
                last_frame_next = '0;
            end
            KIND_EVAL:
            begin
                if (latched_reg)
                begin
                    if (in_data.avoidance_valid)
                        avoid_next = (avoid_reg == STREAK_MAX) ? avoid_reg : avoid_reg + 1'b1;
                    else
                        avoid_next = '0;
                    if (stopped && !in_data.obstacles_empty && in_data.corridor_clear)
                    begin
                        if (in_data.frame_sequence != last_frame_reg)
                        begin
                            clear_next = (clear_reg == STREAK_MAX) ? clear_reg
                                                                   : clear_reg + 1'b1;
                            last_frame_next = in_data.frame_sequence;
                        end
                    end
                    else
                    begin
                        clear_next      = '0;
                        last_frame_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Context handed to the remainder pipeline
    always_comb
    begin
        pipe_next.active    = latched_reg;
        pipe_next.stopped   = stopped;
        pipe_next.cond_b    = (CW'(avoid_next) >= CW'(need)) && in_data.can_select_avoidance;
        pipe_next.cond_c    = CW'(clear_next) >= CW'(need);
        pipe_next.neg       = diff[PW];
        pipe_next.rem       = '0;
        pipe_next.dividend  = POS_W'(dist_mag);
        pipe_next.pass_need = REM_W'(danger_reg) + REM_W'(cfg.pass_margin);
        pipe_next.avoid_out = STREAK_O_W'(avoid_next);
        pipe_next.clear_out = STREAK_O_W'(clear_next);
    end

    // State registers, updated when the item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg    <= 1'b0;
            start_reg      <= '0;
            danger_reg     <= '0;
            avoid_reg      <= '0;
            clear_reg      <= '0;
            last_frame_reg <= '0;
            valid_reg      <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid && (in_kind == KIND_EVAL);
            if (in_valid)
            begin
                latched_reg    <= latched_next;
                start_reg      <= start_next;
                danger_reg     <= danger_next;
                avoid_reg      <= avoid_next;
                clear_reg      <= clear_next;
                last_frame_reg <= last_frame_next;
            end
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        if (advance)
            pipe_reg <= pipe_next;
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;

endmodule

### rtl/ssrs_mod_step.sv
// ============================================================================
// Remainder step
// One restoring step of the distance-modulo-lap reduction, registered.
// ============================================================================
module ssrs_mod_step #(
    parameter int PW   = 20,
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic [ssrs_pkg::POS_W-1:0] track_len,
    input  logic            in_valid,
    input  ssrs_pkg::pipe_t in_pipe,
    output logic            out_valid,
    output ssrs_pkg::pipe_t out_pipe
);
    import ssrs_pkg::*;

    localparam int BIT = PW - 1 - STEP;

    logic [REM_W-1:0] trial;
    logic             valid_reg;
    pipe_t            pipe_reg, pipe_next;

    // Shift in the next dividend bit and subtract the lap length if it fits
    always_comb
    begin
        trial     = {in_pipe.rem[REM_W-2:0], in_pipe.dividend[BIT]};
        pipe_next = in_pipe;
        if (trial >= {1'b0, track_len})
            pipe_next.rem = trial - {1'b0, track_len};
        else
            pipe_next.rem = trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            pipe_reg <= pipe_next;
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;

endmodule

### rtl/ssrs_decide.sv
// ============================================================================
// Release decision
// Folds the remainder onto the lap, tests the pass rule and forms the result.
// ============================================================================
module ssrs_decide (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic [ssrs_pkg::POS_W-1:0] track_len,
    input  logic            in_valid,
    input  ssrs_pkg::pipe_t in_pipe,
    output logic            out_valid,
    output ssrs_pkg::out_data_t out_data
);
    import ssrs_pkg::*;

    logic             fix_valid_reg;
    pipe_t            fix_reg, fix_next;
    logic             out_valid_reg;
    out_data_t        out_reg, out_next;
    logic             passed;

    // A negative difference with a nonzero remainder wraps to lap minus remainder
    always_comb
    begin
        fix_next = in_pipe;
        if (in_pipe.neg && (in_pipe.rem != '0))
            fix_next.rem = REM_W'(track_len) - in_pipe.rem;
        else
            fix_next.rem = in_pipe.rem;
    end

    // Pass rule, priority of the release conditions and result packing
    always_comb
    begin
        passed = (track_len != '0) &&
                 ({fix_reg.rem[REM_W-2:0], 1'b0} < {1'b0, track_len}) &&
                 (fix_reg.rem >= fix_reg.pass_need);
        out_next = '0;
        if (!fix_reg.active)
        begin
            out_next.handoff_allowed = 1'b1;
        end
        else
        begin
            out_next.is_active        = 1'b1;
            out_next.obstacle_passed  = passed;
            out_next.vehicle_stopped  = fix_reg.stopped;
            out_next.cond_a           = passed;
            out_next.cond_b           = fix_reg.cond_b;
            out_next.cond_c           = fix_reg.cond_c;
            out_next.avoid_streak_out = fix_reg.avoid_out;
            out_next.clear_streak_out = fix_reg.clear_out;
            if (passed)
            begin
                out_next.release_cause   = CAUSE_PASSED;
                out_next.handoff_allowed = 1'b1;
            end
            else if (fix_reg.cond_b)
            begin
                out_next.release_cause = CAUSE_AVOIDANCE;
            end
            else if (fix_reg.cond_c)
            begin
                out_next.release_cause   = CAUSE_STOPPED_CLEAR;
                out_next.handoff_allowed = 1'b1;
            end
            out_next.release_ok = out_next.release_cause != CAUSE_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            fix_valid_reg <= in_valid;
            out_valid_reg <= fix_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fix_reg <= fix_next;
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### rtl/ssrs_checker.sv
// ============================================================================
// Supervisor port checker
// Watches the result stream of the supervisor top level.
// ============================================================================
module ssrs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic [ssrs_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready
);
    import ssrs_pkg::*;

    out_data_t res;

    assign res = m_tdata;

    // A stalled result is held until its transfer
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An inactive decision only allows handoff
    a_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.is_active |-> res.handoff_allowed && !res.release_ok &&
        (res.release_cause == CAUSE_NONE) && !res.obstacle_passed &&
        (res.avoid_streak_out == '0) && (res.clear_streak_out == '0))
        else $error("inactive result carries release data");

    // Release flag and cause agree, and condition A is obstacle passed
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res.release_ok == (res.release_cause != CAUSE_NONE)) &&
        (res.cond_a == res.obstacle_passed) &&
        ((res.release_cause == CAUSE_PASSED) == res.cond_a))
        else $error("release cause inconsistent");

    // Handoff while active follows the cause priority
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.is_active |-> res.handoff_allowed ==
        ((res.release_cause == CAUSE_PASSED) ||
         (res.release_cause == CAUSE_STOPPED_CLEAR)))
        else $error("handoff does not match release cause");

endmodule

bind safe_stop_release_supervisor_top ssrs_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

### tb/sv/safe_stop_release_supervisor_top_test.sv
// ============================================================================
// Safe-stop release supervisor testbench
// Drives item streams and register settings into the supervisor, predicts every
// decision in a local model of the latch, lap-distance and streak logic, and
// checks each result transfer field by field against the oldest prediction.
// ============================================================================
module safe_stop_release_supervisor_top_test;

    import ssrs_pkg::*;

    localparam int         STREAK_CAP   = (1 << STREAK_O_W) - 1;
    localparam logic [1:0] KIND_IGNORED = 2'd3;
    localparam int         DRAIN_CYCLES = POS_W + 8;
    localparam int         PHASE_ITEMS  = 150;
    localparam int         SOAK_ITEMS   = STREAK_CAP + 5;

    typedef enum int {READY_ALWAYS, READY_PATTERN, READY_RANDOM} ready_mode_e;

    typedef struct {
        logic [1:0] kind;
        in_data_t   data;
    } pending_item_t;

    // Clock, reset and block ports; the inputs are known from time zero.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic [1:0]            s_tuser   = '0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [POS_W-1:0]      cfg_data  = '0;

    // Stimulus store and bookkeeping.
    pending_item_t pending_items[$];
    out_data_t     expected_decisions[$];
    int            items_queued      = 0;
    int            items_accepted    = 0;
    int            decisions_checked = 0;
    int            registers_written = 0;
    int            error_count       = 0;

    // Idling controls, set between phases.
    int            sender_max_burst = 0;
    int            sender_max_gap   = 0;
    ready_mode_e   ready_mode       = READY_ALWAYS;
    logic [15:0]   ready_pattern    = 16'hFFFF;
    int            burst_left       = 0;
    int            gap_left         = 0;
    int            ready_tick       = 0;

    // Local copy of the supervisor registers and state.
    logic [POS_W-1:0]     lap_mm       = '0;
    logic [POS_W-1:0]     margin_mm    = '0;
    logic [STOP_W-1:0]    stop_speed   = '0;
    logic [CONFIRM_W-1:0] confirm_need = 8'd1;
    logic                 sup_latched  = 1'b0;
    logic [POS_W-1:0]     sup_start_mm = '0;
    logic [POS_W-1:0]     sup_danger_mm = '0;
    int unsigned          avoid_run    = 0;
    int unsigned          clear_run    = 0;
    logic [SEQ_W-1:0]     last_clear_seq = '0;

    safe_stop_release_supervisor_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, period 20.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Print one line for each of the first 30 mismatches, keeping the log short, and count them all.
    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        if (error_count < 30)
        begin
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        end
        error_count++;
    endtask

    // Advance the local supervisor by one accepted item and store any decision.
    task automatic advance_supervisor(input logic [1:0] kind, input in_data_t d);
        out_data_t res;
        longint    diff;
        longint    wrapped;
        longint    speed_mag;
        logic      passed;
        logic      stopped;
        logic      ca;
        logic      cb;
        logic      cc;
        int unsigned need;
        res = '0;
        case (kind)
            KIND_ACTIVATE:
            begin
                sup_latched    = 1'b1;
                sup_start_mm   = d.activation_position_mm;
                sup_danger_mm  = d.danger_end_mm;
                avoid_run      = 0;
                clear_run      = 0;
                last_clear_seq = '0;
            end
            KIND_RESET:
            begin
                sup_latched    = 1'b0;
                sup_start_mm   = '0;
                sup_danger_mm  = '0;
                avoid_run      = 0;
                clear_run      = 0;
                last_clear_seq = '0;
            end
            KIND_EVAL:
            begin
                if (!sup_latched)
                begin
                    res.handoff_allowed = 1'b1;
                end
                else
                begin
                    // Forward distance since activation, wrapped onto the lap.
                    passed = 1'b0;
                    if (lap_mm != 0)
                    begin
                        diff    = longint'(d.ego_position_mm) - longint'(sup_start_mm);
                        wrapped = diff % longint'(lap_mm);
                        if (wrapped < 0)
                        begin
                            wrapped += longint'(lap_mm);
                        end
                        passed = (2 * wrapped < longint'(lap_mm)) &&
                                 (wrapped >= longint'(sup_danger_mm) + longint'(margin_mm));
                    end
                    speed_mag = longint'($signed(d.ego_speed_mm_s));
                    if (speed_mag < 0)
                    begin
                        speed_mag = -speed_mag;
                    end
                    stopped = speed_mag <= longint'(stop_speed);

                    // Saturating streaks of valid avoidance and distinct clear frames.
                    if (d.avoidance_valid)
                    begin
                        avoid_run = (avoid_run >= STREAK_CAP) ? STREAK_CAP : avoid_run + 1;
                    end
                    else
                    begin
                        avoid_run = 0;
                    end
                    if (stopped && !d.obstacles_empty && d.corridor_clear)
                    begin
                        if (d.frame_sequence != last_clear_seq)
                        begin
                            clear_run = (clear_run >= STREAK_CAP) ? STREAK_CAP : clear_run + 1;
                            last_clear_seq = d.frame_sequence;
                        end
                    end
                    else
                    begin
                        clear_run      = 0;
                        last_clear_seq = '0;
                    end

                    need = (confirm_need == 0) ? 1 : confirm_need;
                    ca   = passed;
                    cb   = (avoid_run >= need) && d.can_select_avoidance;
                    cc   = clear_run >= need;

                    res.is_active        = 1'b1;
                    res.obstacle_passed  = passed;
                    res.vehicle_stopped  = stopped;
                    res.cond_a           = ca;
                    res.cond_b           = cb;
                    res.cond_c           = cc;
                    res.avoid_streak_out = avoid_run[STREAK_O_W-1:0];
                    res.clear_streak_out = clear_run[STREAK_O_W-1:0];
                    if (ca)
                    begin
                        res.release_cause   = CAUSE_PASSED;
                        res.handoff_allowed = 1'b1;
                    end
                    else if (cb)
                    begin
                        res.release_cause = CAUSE_AVOIDANCE;
                    end
                    else if (cc)
                    begin
                        res.release_cause   = CAUSE_STOPPED_CLEAR;
                        res.handoff_allowed = 1'b1;
                    end
                    else
                    begin
                        res.release_cause = CAUSE_NONE;
                    end
                    res.release_ok = res.release_cause != CAUSE_NONE;
                end
                expected_decisions.push_back(res);
            end
            default:
            begin
            end
        endcase
    endtask

    // Item driver: sends queued items in bursts separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin : item_driver
        pending_item_t next_item;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                advance_supervisor(s_tuser, s_tdata);
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    next_item = pending_items.pop_front();
                    s_tuser  <= next_item.kind;
                    s_tdata  <= next_item.data;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, sender_max_burst);
                        gap_left   = $urandom_range(0, sender_max_gap);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each result transfer and sets the next ready.
    always @(posedge clk or negedge rst_n)
    begin : decision_monitor
        out_data_t got;
        out_data_t want;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_tick = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_decisions.size() == 0)
                begin
                    report_mismatch("result with none expected", got, '0);
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    decisions_checked++;
                    if (got.is_active !== want.is_active)
                        report_mismatch("is_active", got.is_active, want.is_active);
                    if (got.obstacle_passed !== want.obstacle_passed)
                        report_mismatch("obstacle_passed", got.obstacle_passed,
                                        want.obstacle_passed);
                    if (got.vehicle_stopped !== want.vehicle_stopped)
                        report_mismatch("vehicle_stopped", got.vehicle_stopped,
                                        want.vehicle_stopped);
                    if (got.cond_a !== want.cond_a)
                        report_mismatch("cond_a", got.cond_a, want.cond_a);
                    if (got.cond_b !== want.cond_b)
                        report_mismatch("cond_b", got.cond_b, want.cond_b);
                    if (got.cond_c !== want.cond_c)
                        report_mismatch("cond_c", got.cond_c, want.cond_c);
                    if (got.release_ok !== want.release_ok)
                        report_mismatch("release_ok", got.release_ok, want.release_ok);
                    if (got.release_cause !== want.release_cause)
                        report_mismatch("release_cause", got.release_cause, want.release_cause);
                    if (got.handoff_allowed !== want.handoff_allowed)
                        report_mismatch("handoff_allowed", got.handoff_allowed,
                                        want.handoff_allowed);
                    if (got.avoid_streak_out !== want.avoid_streak_out)
                        report_mismatch("avoid_streak_out", got.avoid_streak_out,
                                        want.avoid_streak_out);
                    if (got.clear_streak_out !== want.clear_streak_out)
                        report_mismatch("clear_streak_out", got.clear_streak_out,
                                        want.clear_streak_out);
                end
            end
            ready_tick++;
            case (ready_mode)
                READY_ALWAYS:  m_tready <= 1'b1;
                READY_PATTERN: m_tready <= ready_pattern[ready_tick % 16];
                default:       m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Write one register over the configuration channel and mirror it locally.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] value);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            REG_TRACK_LEN:   lap_mm       = value;
            REG_PASS_MARGIN: margin_mm    = value;
            REG_STOPPED_SPD: stop_speed   = value[STOP_W-1:0];
            REG_CONFIRM:     confirm_need = value[CONFIRM_W-1:0];
            default:
            begin
            end
        endcase
        registers_written++;
    endtask

    // Write all four registers plus one index that the block must ignore.
    task automatic write_settings(input logic [POS_W-1:0] track, input logic [POS_W-1:0] margin,
                                  input logic [POS_W-1:0] stop, input logic [POS_W-1:0] confirm);
        write_reg(REG_TRACK_LEN, track);
        write_reg(REG_PASS_MARGIN, margin);
        write_reg(REG_STOPPED_SPD, stop);
        write_reg(REG_CONFIRM, confirm);
        write_reg(CFG_IDX_W'($urandom_range(REG_CONFIRM + 1, 255)), POS_W'($urandom));
    endtask

    task automatic set_idling(input int max_burst, input int max_gap, input ready_mode_e mode);
        sender_max_burst = max_burst;
        sender_max_gap   = max_gap;
        ready_mode       = mode;
        ready_pattern    = 16'($urandom) | 16'h0001;
    endtask

    // Wait until every item is taken and every decision has come back, then
    // let the pipeline empty of items that give no result.
    task automatic wait_idle();
        while (items_accepted != items_queued || expected_decisions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic in_data_t random_payload();
        in_data_t d;
        d.pad                    = '0;
        d.ego_position_mm        = POS_W'($urandom);
        d.ego_speed_mm_s         = SPEED_W'($urandom);
        d.avoidance_valid        = $urandom_range(0, 1);
        d.can_select_avoidance   = $urandom_range(0, 1);
        d.obstacles_empty        = $urandom_range(0, 1);
        d.corridor_clear         = $urandom_range(0, 1);
        d.frame_sequence         = $urandom;
        d.activation_position_mm = POS_W'($urandom);
        d.danger_end_mm          = POS_W'($urandom);
        return d;
    endfunction

    task automatic queue_item(input logic [1:0] kind, input in_data_t d);
        pending_item_t it;
        it.kind = kind;
        it.data = d;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_activate(input logic [POS_W-1:0] start, input logic [POS_W-1:0] danger);
        in_data_t d;
        d = random_payload();
        d.activation_position_mm = start;
        d.danger_end_mm          = danger;
        queue_item(KIND_ACTIVATE, d);
    endtask

    task automatic queue_eval(input logic [POS_W-1:0] pos, input logic signed [SPEED_W-1:0] speed,
                              input logic av, input logic can_sel, input logic empty,
                              input logic clear, input logic [SEQ_W-1:0] seq);
        in_data_t d;
        d = random_payload();
        d.ego_position_mm      = pos;
        d.ego_speed_mm_s       = speed;
        d.avoidance_valid      = av;
        d.can_select_avoidance = can_sel;
        d.obstacles_empty      = empty;
        d.corridor_clear       = clear;
        d.frame_sequence       = seq;
        queue_item(KIND_EVAL, d);
    endtask

    // Random part of one phase: mostly an activation followed by a drive along
    // the lap with plausible speeds and frames, the rest raw noise.
    task automatic queue_random_phase(input int target);
        int counted;
        int run_len;
        int k;
        int pos_i;
        int step;
        int mag;
        int speed_lim;
        int pick;
        logic [1:0]       kind;
        logic [SEQ_W-1:0] seq;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] danger;
        counted = 0;
        while (counted < target)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                kind = $urandom_range(0, 3);
                queue_item(kind, random_payload());
                if (kind != KIND_IGNORED)
                begin
                    counted++;
                end
            end
            else
            begin
                if (lap_mm != 0)
                begin
                    start  = $urandom_range(0, lap_mm - 1);
                    danger = $urandom_range(0, lap_mm / 2);
                end
                else
                begin
                    start  = POS_W'($urandom);
                    danger = $urandom_range(0, 2000);
                end
                queue_activate(start, danger);
                counted++;
                pos_i     = start;
                seq       = $urandom_range(0, 3);
                run_len   = $urandom_range(2, 24);
                speed_lim = (2 * stop_speed + 4 > 65535) ? 65535 : 2 * stop_speed + 4;
                for (k = 0; k < run_len; k++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 4)
                    begin
                        queue_item(KIND_RESET, random_payload());
                        counted++;
                    end
                    else if (pick < 6)
                    begin
                        queue_item(KIND_IGNORED, random_payload());
                    end
                    else
                    begin
                        // Move forward along the lap.
                        if (lap_mm != 0)
                        begin
                            step  = $urandom_range(0, lap_mm / 8 + 1);
                            pos_i = (pos_i + step) % lap_mm;
                        end
                        else
                        begin
                            pos_i = (pos_i + $urandom_range(0, 500)) % (1 << POS_W);
                        end
                        // Frame numbers mostly advance, sometimes repeat or restart.
                        pick = $urandom_range(0, 19);
                        if (pick < 14)
                            seq = seq + 1;
                        else if (pick == 17)
                            seq = '0;
                        else if (pick > 17)
                            seq = $urandom;
                        mag = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, speed_lim);
                        if ($urandom_range(0, 1))
                            mag = -mag;
                        step = pos_i;
                        if ($urandom_range(0, 9) == 0 && pos_i + lap_mm < (1 << POS_W))
                            step = pos_i + lap_mm;
                        queue_eval(step, mag, $urandom_range(0, 9) < 8,
                                   $urandom_range(0, 9) < 7, $urandom_range(0, 9) == 0,
                                   $urandom_range(0, 9) < 8, seq);
                        counted++;
                    end
                end
            end
        end
    endtask

    // Safety net against a hung handshake.
    initial
    begin
        #30000000;
        $display("safe_stop_release_supervisor_top test failed");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        int k;
        logic [POS_W-1:0]     track_pick;
        logic [POS_W-1:0]     margin_pick;
        logic [POS_W-1:0]     stop_pick;
        logic [POS_W-1:0]     confirm_pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed cases under reset register values: inactive decision, a
        // frame numbered zero, a repeated frame, kind three and a reset item.
        set_idling(3, 2, READY_PATTERN);
        queue_eval(20'hFFFFF, -1, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        queue_activate(20'hFFFFF, 20'hFFFFF);
        queue_eval(20'd0, 0, 1'b1, 1'b1, 1'b0, 1'b1, 32'd0);
        queue_eval(20'd0, 0, 1'b1, 1'b1, 1'b0, 1'b1, 32'd7);
        queue_eval(20'd0, 0, 1'b1, 1'b1, 1'b0, 1'b1, 32'd7);
        queue_eval(20'd0, 1, 1'b1, 1'b1, 1'b0, 1'b1, 32'd8);
        queue_item(KIND_IGNORED, random_payload());
        queue_item(KIND_RESET, random_payload());
        queue_eval(20'd5, 0, 1'b1, 1'b1, 1'b0, 1'b1, 32'd9);
        wait_idle();

        // Directed lap cases: passed at exactly danger end plus margin, the
        // half-lap guard, positions beyond the lap and behind the start, speed
        // extremes and the stopped threshold, and each release cause.
        write_settings(20'd1000, 20'd50, 20'd100, 20'd2);
        queue_activate(20'd900, 20'd100);
        queue_eval(20'd1050, -100, 1'b1, 1'b1, 1'b0, 1'b1, 32'd1);
        queue_eval(20'd600, 100, 1'b1, 1'b1, 1'b0, 1'b1, 32'd2);
        queue_eval(20'd2000, -65536, 1'b1, 1'b0, 1'b0, 1'b1, 32'd3);
        queue_eval(20'd899, 65535, 1'b0, 1'b1, 1'b0, 1'b1, 32'd4);
        queue_eval(20'd0, -101, 1'b1, 1'b1, 1'b0, 1'b1, 32'd4);
        queue_eval(20'd1049, 50, 1'b0, 1'b1, 1'b0, 1'b1, 32'd5);
        queue_eval(20'd1049, -50, 1'b0, 1'b1, 1'b0, 1'b1, 32'd6);
        queue_eval(20'd1049, 0, 1'b0, 1'b1, 1'b1, 1'b1, 32'd7);
        wait_idle();

        // Random phases, each under its own register setting and idling style.
        for (p = 0; p < 7; p++)
        begin
            track_pick   = $urandom_range(1000, 200000);
            margin_pick  = $urandom_range(0, 2000);
            stop_pick    = $urandom_range(0, 3000);
            confirm_pick = $urandom_range(1, 5);
            case (p)
                0:
                begin
                    track_pick   = '0;
                    confirm_pick = '0;
                end
                1:
                begin
                    track_pick   = 20'd1;
                    margin_pick  = '0;
                    stop_pick    = '0;
                    confirm_pick = 20'd1;
                end
                2:
                begin
                    track_pick = 20'hFFFFF;
                    stop_pick  = 20'hFFFFF;
                end
                3:
                begin
                    margin_pick  = 20'hFFFFF;
                    confirm_pick = 20'hFFFFF;
                end
                4:
                begin
                    margin_pick = '0;
                end
                default:
                begin
                end
            endcase
            write_settings(track_pick, margin_pick, stop_pick, confirm_pick);
            case (p % 3)
                0:       set_idling(0, 0, READY_ALWAYS);
                1:       set_idling(5, 6, READY_PATTERN);
                default: set_idling(8, 3, READY_RANDOM);
            endcase
            queue_random_phase(PHASE_ITEMS);
            wait_idle();
        end

        // Long unbroken streaks to drive both counters into saturation.
        write_settings(20'd0, 20'd0, 20'hFFFFF, 20'd255);
        set_idling(0, 0, READY_ALWAYS);
        queue_activate(POS_W'($urandom), POS_W'($urandom));
        for (k = 0; k < SOAK_ITEMS; k++)
        begin
            queue_eval(POS_W'($urandom), $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                             : -$urandom_range(0, 65535),
                       1'b1, $urandom_range(0, 1), 1'b0, 1'b1, SEQ_W'(k + 1));
        end
        queue_eval(POS_W'($urandom), 0, 1'b0, 1'b1, 1'b1, 1'b1, 32'd1);
        wait_idle();

        $display("Checked %0d decisions from %0d input transfers, %0d register writes.",
                 decisions_checked, items_accepted, registers_written);
        $display("Covered directed lap corners, random drive sequences and streak saturation.");
        if (error_count == 0)
        begin
            $display("safe_stop_release_supervisor_top test passed");
        end
        else
        begin
            $display("safe_stop_release_supervisor_top test failed");
        end
        $finish;
    end

endmodule
